// ===== src/bmtu_pkg.sv =====
// ----------------------------------------------------------------------------
// bmtu_pkg
// Shared types, request codes and the 2x2-to-4x4 template table for the
// binary mask template upscaler.
// ----------------------------------------------------------------------------
package bmtu_pkg;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_BLOCK = 1'b1;

    localparam logic [7:0] PIX_CLEAR = 8'h00;
    localparam logic [7:0] PIX_SET   = 8'hFF;

    typedef struct packed {
        logic       req_type;
        logic [6:0] pos_x;
        logic [6:0] pos_y;
        logic [7:0] pixel_value;
    } t_in;

    typedef struct packed {
        logic [6:0]  block_x;
        logic [6:0]  block_y;
        logic [31:0] row0;
        logic [31:0] row1;
        logic [31:0] row2;
        logic [31:0] row3;
        logic        bad_corner;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic wr_en;
        logic rd_en;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_valid;
    } t_sts;

    // rows packed top to bottom: row0 in [127:96], row3 in [31:0]
    function automatic logic [127:0] tmpl_rows(input logic [3:0] key);
        logic [127:0] rows;
        unique case (key)
            4'h0: rows = {32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000};
            4'h1: rows = {32'h00000000, 32'h00000000, 32'h80000000, 32'hFF800000};
            4'h2: rows = {32'h00000000, 32'h00000000, 32'h00000080, 32'h000080FF};
            4'h3: rows = {32'h00000000, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF};
            4'h4: rows = {32'hFF800000, 32'h80000000, 32'h00000000, 32'h00000000};
            4'h5: rows = {32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000};
            4'h6: rows = {32'hFF800000, 32'h80000000, 32'h00000080, 32'h000080FF};
            4'h7: rows = {32'hFFFF8000, 32'hFFFFFF80, 32'hFFFFFFFF, 32'hFFFFFFFF};
            4'h8: rows = {32'h000080FF, 32'h00000080, 32'h00000000, 32'h00000000};
            4'h9: rows = {32'h000080FF, 32'h00000080, 32'h80000000, 32'hFF800000};
            4'hA: rows = {32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF};
            4'hB: rows = {32'h0080FFFF, 32'h80FFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
            4'hC: rows = {32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000};
            4'hD: rows = {32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFF80, 32'hFFFF8000};
            4'hE: rows = {32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80FFFFFF, 32'h0080FFFF};
            4'hF: rows = {32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        endcase
        return rows;
    endfunction

endpackage

// ===== src/bmtu_ram.sv =====
// ----------------------------------------------------------------------------
// bmtu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bmtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bmtu_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmtu_ctrl
// Controller: clearing pass after reset, request acceptance and the
// lookup/output step of block requests.
// ----------------------------------------------------------------------------
module bmtu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_req_type,
    input  logic            i_out_ready,
    input  bmtu_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output bmtu_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   w_accept;

    assign w_accept = i_valid && r_in_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.clear_step = (r_state == S_CLEAR);
        o_cmd.wr_en      = w_accept && (i_req_type == bmtu_pkg::REQ_WRITE);
        o_cmd.rd_en      = w_accept && (i_req_type == bmtu_pkg::REQ_BLOCK);
        o_cmd.out_load   = (r_state == S_LOOKUP) && (!i_sts.out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_cmd.rd_en) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                if (o_cmd.out_load) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear_step |-> !(o_cmd.wr_en || o_cmd.rd_en))
        else $error("request taken during clearing pass");

    a_block_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |=> !o_in_ready && (r_state == S_LOOKUP))
        else $error("block request did not enter lookup");

endmodule

// ===== src/bmtu_dp.sv =====
// ----------------------------------------------------------------------------
// bmtu_dp
// Datapath: 2x2 parity-banked source mask, neighbour addressing with
// saturation and edge clamp, template lookup and output register.
// ----------------------------------------------------------------------------
module bmtu_dp #(
    parameter int SIDE = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bmtu_pkg::t_cmd  i_cmd,
    input  bmtu_pkg::t_in   i_data,
    input  logic            i_out_ready,
    output bmtu_pkg::t_sts  o_sts,
    output logic            o_valid,
    output bmtu_pkg::t_out  o_data
);

    localparam int CW    = $clog2(SIDE);
    localparam int HW    = (CW > 1) ? CW - 1 : 1;
    localparam int AW    = 2 * HW;
    localparam int DEPTH = 2 ** AW;

    logic [31:0] w_px, w_py, w_x, w_y, w_xn, w_yn;
    logic        w_wr_ok;
    logic [7:0]  w_rd [4];

    logic [AW-1:0] r_clr;
    logic [6:0]    r_bx, r_by;
    logic          r_x0, r_xn0, r_y0, r_yn0;
    logic          r_out_valid;
    bmtu_pkg::t_out r_out;

    logic [7:0]   w_c [4];
    logic [3:0]   w_key;
    logic         w_bad;
    logic [127:0] w_rows;

    always_comb begin
        w_px    = 32'(i_data.pos_x);
        w_py    = 32'(i_data.pos_y);
        w_wr_ok = (w_px < 32'(SIDE)) && (w_py < 32'(SIDE));
        w_x     = (w_px >= 32'(SIDE)) ? 32'(SIDE - 1) : w_px;
        w_y     = (w_py >= 32'(SIDE)) ? 32'(SIDE - 1) : w_py;
        w_xn    = (w_x + 32'd1 < 32'(SIDE)) ? w_x + 32'd1 : 32'(SIDE - 1);
        w_yn    = (w_y + 32'd1 < 32'(SIDE)) ? w_y + 32'd1 : 32'(SIDE - 1);
    end

    // bank index is {row parity, column parity}
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BK = 2'(b);
        logic [31:0]   w_col, w_row;
        logic [AW-1:0] w_addr;
        logic          w_we;

        always_comb begin
            w_col = (w_x[0] == BK[0]) ? w_x : w_xn;
            w_row = (w_y[0] == BK[1]) ? w_y : w_yn;
            w_we  = i_cmd.clear_step ||
                    (i_cmd.wr_en && w_wr_ok && (w_px[0] == BK[0]) && (w_py[0] == BK[1]));
            if (i_cmd.clear_step) begin
                w_addr = r_clr;
            end else if (i_cmd.wr_en) begin
                w_addr = {w_py[HW:1], w_px[HW:1]};
            end else begin
                w_addr = {w_row[HW:1], w_col[HW:1]};
            end
        end

        bmtu_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (w_we || i_cmd.rd_en),
            .i_we    (w_we),
            .i_addr  (w_addr),
            .i_wdata (i_cmd.clear_step ? bmtu_pkg::PIX_CLEAR : i_data.pixel_value),
            .o_rdata (w_rd[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_bx  <= w_x[6:0];
            r_by  <= w_y[6:0];
            r_x0  <= w_x[0];
            r_xn0 <= w_xn[0];
            r_y0  <= w_y[0];
            r_yn0 <= w_yn[0];
        end
    end

    // a clamped neighbour has the same parity, so it reads the same bank
    always_comb begin
        w_c[0] = w_rd[{r_y0,  r_x0}];
        w_c[1] = w_rd[{r_y0,  r_xn0}];
        w_c[2] = w_rd[{r_yn0, r_x0}];
        w_c[3] = w_rd[{r_yn0, r_xn0}];
        w_bad  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            w_key[3-i] = (w_c[i] == bmtu_pkg::PIX_SET);
            if ((w_c[i] != bmtu_pkg::PIX_SET) && (w_c[i] != bmtu_pkg::PIX_CLEAR)) begin
                w_bad = 1'b1;
            end
        end
        w_rows = w_bad ? '0 : bmtu_pkg::tmpl_rows(w_key);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.block_x    <= r_bx;
            r_out.block_y    <= r_by;
            r_out.row0       <= w_rows[127:96];
            r_out.row1       <= w_rows[95:64];
            r_out.row2       <= w_rows[63:32];
            r_out.row3       <= w_rows[31:0];
            r_out.bad_corner <= w_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.clear_last = &r_clr;
    assign o_sts.out_valid  = r_out_valid;
    assign o_valid          = r_out_valid;
    assign o_data           = r_out;

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

    a_bad_zero_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.bad_corner) |->
        ((r_out.row0 == '0) && (r_out.row1 == '0) && (r_out.row2 == '0) &&
         (r_out.row3 == '0)))
        else $error("bad corner result carries template rows");

endmodule

// ===== src/binary_mask_template_upscaler_4x_top.sv =====
// ----------------------------------------------------------------------------
// binary_mask_template_upscaler_4x_top
// 4x upscaler of a binary byte mask: pixel writes and 2x2-to-4x4 template
// block requests against a parity-banked source mask.
// ----------------------------------------------------------------------------
//  channel   valid     ready     payload   direction
//  request   i_valid   o_ready   i_data    in   (bmtu_pkg::t_in)
//  result    o_valid   i_ready   o_data    out  (bmtu_pkg::t_out)
//
//  a write request gives no result
//  a block request is a registered read of all four banks,
//  then template lookup into the output register
//  after reset the banks are cleared one address a cycle over all 2**(2*HW)
//  addresses (4096 at SIDE = 128), while o_ready stays low
//  a stalled result holds in the output register; a following block request
//  waits in lookup until that register drains
// ----------------------------------------------------------------------------
module binary_mask_template_upscaler_4x_top #(
    parameter int SIDE = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bmtu_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output bmtu_pkg::t_out o_data
);

    bmtu_pkg::t_cmd w_cmd;
    bmtu_pkg::t_sts w_sts;

    bmtu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_req_type  (i_data.req_type),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_ready),
        .o_cmd       (w_cmd)
    );

    bmtu_dp #(
        .SIDE (SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data      (i_data),
        .i_out_ready (i_ready),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_data      (o_data)
    );

endmodule
